>>> design/matt_pkg.sv
// Shared types and codes for the multi-alarm timer table.
// Holds the request and response payload structs and the cell control structs.
// Used by matt_cell and multi_alarm_timer_table_top; depends on nothing.
package matt_pkg;

   // Default table size and the cap on results per wake request.
   localparam int DEFAULT_SLOTS = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int HIT_W         = 5;

   // Operation codes.
   localparam logic [2:0] F_ALLOC   = 3'd0;
   localparam logic [2:0] F_ARM     = 3'd1;
   localparam logic [2:0] F_WAKE    = 3'd2;
   localparam logic [2:0] F_RELEASE = 3'd3;
   localparam logic [2:0] F_DISABLE = 3'd4;

   // Response status codes.
   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_FULL          = 3'd1;
   localparam logic [2:0] ST_NOT_ALLOCATED = 3'd2;
   localparam logic [2:0] ST_FIRED         = 3'd3;
   localparam logic [2:0] ST_NONE_DUE      = 3'd4;

   // Slot modes.
   localparam logic [1:0] MODE_AVAILABLE = 2'd0;
   localparam logic [1:0] MODE_DISABLED  = 2'd1;
   localparam logic [1:0] MODE_ENABLED   = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  alarm_id;
      logic [63:0] delay;
      logic [63:0] now;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot;
      logic       last;
   } rsp_type;

   // Broadcast commands from the sequencer to every cell of the chain.
   typedef struct packed {
      logic        step;          // token moves one cell down the chain
      logic        start;         // token enters the first cell on a step
      logic        kill;          // token is dropped from the chain
      logic        claim;         // cell holding the token becomes allocated
      logic        arm;           // selected cell takes a new deadline
      logic        rel;           // selected cell is freed
      logic        dis;           // selected cell is disabled
      logic        wrapped;       // new deadline wrapped
      logic [63:0] deadline;
   } ctl_type;

   // Registered request context that every cell uses for its hit test.
   typedef struct packed {
      logic        alloc_scan;    // token looks for a free slot, not a due one
      logic        time_wrapped;  // tick count wrapped at this wake
      logic [63:0] now;
   } scan_type;

endpackage

>>> design/matt_cell.sv
// One alarm slot of the timer table chain: deadline, mode and scan token.
// The token is handed from the previous cell to this one on each scan step.
// Depends on matt_pkg.
module matt_cell (
   input  logic               clock,
   input  logic               reset,
   input  matt_pkg::ctl_type  ctl,
   input  matt_pkg::scan_type scan,
   input  logic               sel,
   input  logic               tok_prev,
   output logic               tok_out,
   output logic               hit,
   output logic               taken
);

   logic [1:0]  mode_ff, mode_in;
   logic        taken_ff, taken_in;
   logic        tok_ff, tok_in;
   logic [63:0] deadline_ff, deadline_in;
   logic        wrap_ff, wrap_in;
   logic        reached;
   logic        no_wrap;
   logic        due;

   // Due test under the three-term wrap rule.
   assign reached = scan.now >= deadline_ff;
   assign no_wrap = !wrap_ff;
   assign due     = (mode_ff == matt_pkg::MODE_ENABLED) &&
                    ((no_wrap && reached) || (scan.time_wrapped && reached) ||
                     (no_wrap && scan.time_wrapped));

   assign hit     = tok_ff && (scan.alloc_scan ? !taken_ff : due);
   assign tok_out = tok_ff;
   assign taken   = taken_ff;

   // Next state of the slot and of the token.
   always_comb begin
      mode_in     = mode_ff;
      taken_in    = taken_ff;
      tok_in      = tok_ff;
      deadline_in = deadline_ff;
      wrap_in     = wrap_ff;
      if (ctl.kill) begin
         tok_in = 1'b0;
      end else if (ctl.step) begin
         tok_in = tok_prev;
      end
      if (ctl.claim && tok_ff) begin
         taken_in    = 1'b1;
         mode_in     = matt_pkg::MODE_DISABLED;
         deadline_in = '0;
         wrap_in     = 1'b0;
      end
      if (sel && ctl.arm) begin
         deadline_in = ctl.deadline;
         wrap_in     = ctl.wrapped;
         mode_in     = matt_pkg::MODE_ENABLED;
      end
      if (sel && ctl.rel) begin
         mode_in  = matt_pkg::MODE_AVAILABLE;
         taken_in = 1'b0;
      end
      if (sel && ctl.dis) begin
         mode_in = matt_pkg::MODE_DISABLED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= matt_pkg::MODE_AVAILABLE;
         taken_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         taken_ff <= taken_in;
         tok_ff   <= tok_in;
      end
   end

   // Deadline storage is only read after an arm has written it.
   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      wrap_ff     <= wrap_in;
   end

endmodule

>>> design/multi_alarm_timer_table_top.sv
// Multi-alarm timer table: a chain of alarm slot cells and its sequencer.
// Depends on matt_pkg and matt_cell.
//
// Requests arrive on req_valid/req_ready/req_data and carry one operation:
// allocate, arm, wake, release or disable. Responses leave on
// rsp_valid/rsp_ready/rsp_data; every request gives one response with last
// set, except wake, which gives one response per fired slot in ascending
// slot order (at most sixteen) with last on the final one, or one none-due response.
// A request is taken whenever no other request is in progress, even while
// the previous response still waits in the output register.
// Arm, release and disable answer from the execute state once the output
// register is free. Allocate and wake walk a token down the slot chain one
// cell per cycle unless the output stalls; allocate stops at the first free
// slot, or answers full at once when every slot is already allocated.
// When the receiver stalls, the walk holds at the next response it needs to
// send and resumes when the output register frees up.
// Synchronous reset frees all slots, clears the allocation count and the
// last wake time, and drops any request in progress.
module multi_alarm_timer_table_top #(
   parameter int ALARM_SLOTS = matt_pkg::DEFAULT_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  matt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output matt_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
   localparam int CNT_W = $clog2(ALARM_SLOTS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [2:0]                 func_ff, func_in;
   logic [3:0]                 id_ff, id_in;
   logic [63:0]                delay_ff, delay_in;
   logic [63:0]                now_ff, now_in;
   logic [63:0]                prev_now_ff, prev_now_in;
   logic                       twrap_ff, twrap_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [matt_pkg::HIT_W-1:0] hits_ff, hits_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic [3:0]                 pend_slot_ff, pend_slot_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   matt_pkg::rsp_type          rsp_ff, rsp_in;

   matt_pkg::ctl_type          ctl;
   matt_pkg::scan_type         scan;
   logic [ALARM_SLOTS-1:0]     sel_vec;
   logic [ALARM_SLOTS-1:0]     tok_vec;
   logic [ALARM_SLOTS-1:0]     hit_vec;
   logic [ALARM_SLOTS-1:0]     taken_vec;
   logic [64:0]                sum;
   logic                       valid_id;
   logic                       taken_sel;
   logic                       out_free;
   logic                       any_hit;
   logic                       is_last;
   logic                       emit;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sum       = {1'b0, now_ff} + {1'b0, delay_ff};
   assign valid_id  = 32'(id_ff) < 32'(ALARM_SLOTS);
   assign taken_sel = |(sel_vec & taken_vec);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign any_hit   = |hit_vec;
   assign is_last   = idx_ff == IDX_W'(ALARM_SLOTS - 1);

   // Request context seen by every cell for its hit test.
   assign scan = '{alloc_scan:   (func_ff == matt_pkg::F_ALLOC),
                   time_wrapped: twrap_ff,
                   now:          now_ff};

   // Chain of slot cells; the token enters at cell zero.
   for (genvar k = 0; k < ALARM_SLOTS; k++) begin : g_cell
      assign sel_vec[k] = valid_id && (32'(id_ff) == 32'(k));
      matt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .scan     (scan),
         .sel      (sel_vec[k]),
         .tok_prev ((k == 0) ? ctl.start : tok_vec[(k == 0) ? 0 : k - 1]),
         .tok_out  (tok_vec[k]),
         .hit      (hit_vec[k]),
         .taken    (taken_vec[k])
      );
   end

   // Sequencer: request capture, direct slot updates and chain walks.
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      id_in         = id_ff;
      delay_in      = delay_ff;
      now_in        = now_ff;
      prev_now_in   = prev_now_ff;
      twrap_in      = twrap_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      hits_in       = hits_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_in        = rsp_ff;
      emit          = 1'b0;

      ctl              = '0;
      ctl.wrapped      = sum[64];
      ctl.deadline     = sum[63:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in  = req_data.func;
               id_in    = req_data.alarm_id;
               delay_in = req_data.delay;
               now_in   = req_data.now;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            idx_in        = '0;
            hits_in       = '0;
            pend_valid_in = 1'b0;
            if (func_ff == matt_pkg::F_ALLOC) begin
               if (count_ff >= CNT_W'(ALARM_SLOTS)) begin
                  if (out_free) begin
                     emit     = 1'b1;
                     rsp_in   = '{status: matt_pkg::ST_FULL, slot: 4'd0, last: 1'b1};
                     state_in = S_IDLE;
                  end
               end else begin
                  ctl.step  = 1'b1;
                  ctl.start = 1'b1;
                  state_in  = S_SCAN;
               end
            end else if (func_ff == matt_pkg::F_WAKE) begin
               twrap_in    = prev_now_ff > now_ff;
               prev_now_in = now_ff;
               ctl.step    = 1'b1;
               ctl.start   = 1'b1;
               state_in    = S_SCAN;
            end else if (out_free) begin
               emit     = 1'b1;
               rsp_in   = '{status: matt_pkg::ST_OK, slot: 4'd0, last: 1'b1};
               state_in = S_IDLE;
               if (func_ff == matt_pkg::F_ARM) begin
                  if (taken_sel) begin
                     ctl.arm = 1'b1;
                  end else begin
                     rsp_in.status = matt_pkg::ST_NOT_ALLOCATED;
                  end
               end else if (func_ff == matt_pkg::F_RELEASE) begin
                  if (taken_sel) begin
                     ctl.rel = 1'b1;
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end else begin
                     rsp_in.status = matt_pkg::ST_NOT_ALLOCATED;
                  end
               end else if (func_ff == matt_pkg::F_DISABLE) begin
                  if (taken_sel) begin
                     ctl.dis = 1'b1;
                  end else begin
                     rsp_in.status = matt_pkg::ST_NOT_ALLOCATED;
                  end
               end
            end
         end
         S_SCAN: begin
            if (!any_hit) begin
               ctl.step = 1'b1;
               idx_in   = idx_ff + IDX_W'(1);
               if (is_last) begin
                  state_in = S_DONE;
               end
            end else if (func_ff == matt_pkg::F_ALLOC) begin
               // First free slot found: claim it and answer.
               if (out_free) begin
                  ctl.claim = 1'b1;
                  ctl.kill  = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  emit      = 1'b1;
                  rsp_in    = '{status: matt_pkg::ST_OK, slot: 4'(idx_ff), last: 1'b1};
                  state_in  = S_IDLE;
               end
            end else if (!pend_valid_ff || out_free) begin
               // A due slot: send the one held back, hold this one.
               if (pend_valid_ff) begin
                  emit   = 1'b1;
                  rsp_in = '{status: matt_pkg::ST_FIRED, slot: pend_slot_ff, last: 1'b0};
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = 4'(idx_ff);
               hits_in       = hits_ff + matt_pkg::HIT_W'(1);
               if (is_last || hits_ff == matt_pkg::HIT_W'(matt_pkg::MAX_RESULTS - 1)) begin
                  ctl.kill = 1'b1;
                  state_in = S_DONE;
               end else begin
                  ctl.step = 1'b1;
                  idx_in   = idx_ff + IDX_W'(1);
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (func_ff == matt_pkg::F_ALLOC) begin
                  rsp_in = '{status: matt_pkg::ST_FULL, slot: 4'd0, last: 1'b1};
               end else if (pend_valid_ff) begin
                  rsp_in = '{status: matt_pkg::ST_FIRED, slot: pend_slot_ff, last: 1'b1};
               end else begin
                  rsp_in = '{status: matt_pkg::ST_NONE_DUE, slot: 4'd0, last: 1'b1};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         prev_now_ff   <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_now_ff   <= prev_now_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      id_ff        <= id_in;
      delay_ff     <= delay_in;
      now_ff       <= now_in;
      twrap_ff     <= twrap_in;
      idx_ff       <= idx_in;
      hits_ff      <= hits_in;
      pend_slot_ff <= pend_slot_in;
      rsp_ff       <= rsp_in;
   end

   // The token is in exactly one cell while a walk is under way.
   a_token_during_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> $onehot(tok_vec))
      else $error("scan token lost or duplicated");

   // No token is left in the chain outside a walk.
   a_token_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SCAN) |-> (tok_vec == '0))
      else $error("stray scan token");

   // The allocation count tracks the allocated cells.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      32'($countones(taken_vec)) == 32'(count_ff))
      else $error("allocation count out of step with slots");

   // A held fired slot exists only while a wake walk is running or closing.
   a_pend_in_wake: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && (state_ff == S_SCAN || state_ff == S_DONE)
         |-> (func_ff == matt_pkg::F_WAKE))
      else $error("held fired slot outside a wake");

endmodule
